// File: src/brf_pkg.sv
// Package for the byte ring FIFO: field widths, command codes and the
// control and status structs passed between the controller and the datapath.
// Depends on nothing; every other file of the block but brf_ram imports it.
package brf_pkg;

    localparam int CMD_W     = 3;
    localparam int DATA_W    = 8;
    localparam int OFFSET_W  = 6;
    localparam int FILL_W    = 6;
    localparam int DEPTH_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Which pointer addresses the RAM read port.
    typedef enum logic [1:0] {
        RD_OLDEST = 2'd0,
        RD_NEWEST = 2'd1,
        RD_WALK   = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    in_ready;
        logic    wr_en;
        logic    rp_adv;
        logic    clr;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    walk_load;
        logic    out_load;
        logic    out_ok;
        logic    out_byte;
        logic    out_last;
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic dump_none;
        logic walk_done;
    } t_sts;

endpackage

// File: src/brf_if.sv
// Handshake interfaces of the byte ring FIFO: command beats in, result beats out.
// Depends on brf_pkg for the field widths.
interface brf_cmd_if import brf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [DATA_W-1:0]   data_in;
    logic [OFFSET_W-1:0] offset;

    modport source(output valid, command, data_in, offset, input ready);
    modport sink(input valid, command, data_in, offset, output ready);
endinterface

interface brf_res_if import brf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_count;
    logic              last;

    modport source(output valid, ok, data_out, fill_count, last, input ready);
    modport sink(input valid, ok, data_out, fill_count, last, output ready);
endinterface

// File: src/brf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/brf_datapath.sv
// Datapath of the byte ring FIFO: pointers, dump walker, byte RAM and result register.
// Depends on brf_pkg and brf_ram; steered by brf_ctrl.
module brf_datapath import brf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic [DATA_W-1:0]   i_data_in,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic                i_out_ready,
    output t_sts                o_sts,
    output logic                o_out_valid,
    output logic                o_ok,
    output logic [DATA_W-1:0]   o_data_out,
    output logic [FILL_W-1:0]   o_fill_count,
    output logic                o_last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    // The wrap term is DEPTH modulo 2**PTR_W, so the sum stays exact below DEPTH.
    function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
                                                   input logic [PTR_W-1:0] r);
        return (w >= r) ? (w - r) : (w - r + PTR_W'(DEPTH));
    endfunction

    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_dptr;
    logic [PTR_W-1:0]  r_dcnt;
    logic              r_out_valid;
    logic              r_out_ok;
    logic              r_out_last;
    logic [DATA_W-1:0] r_out_data;
    logic [FILL_W-1:0] r_out_fill;

    logic [PTR_W-1:0]  fill_now;
    logic [PTR_W-1:0]  fill_next;
    logic [PTR_W-1:0]  off_p;
    logic [PTR_W:0]    start_sum;
    logic [PTR_W-1:0]  start_ptr;
    logic [PTR_W-1:0]  rd_addr;
    logic              walk_step;
    logic [DATA_W-1:0] ram_rdata;

    assign fill_now  = ring_fill(r_wp, r_rp);
    assign off_p     = i_offset[PTR_W-1:0];
    assign start_sum = {1'b0, r_rp} + {1'b0, off_p};
    assign start_ptr = (start_sum >= DEPTH_X) ? PTR_W'(start_sum - DEPTH_X)
                                              : start_sum[PTR_W-1:0];
    assign walk_step = i_ctl.rd_en && (i_ctl.rd_sel == RD_WALK);

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_ctl.clr) begin
            n_wp = '0;
            n_rp = '0;
        end else begin
            if (i_ctl.wr_en) begin
                n_wp = ptr_next(r_wp);
            end
            if (i_ctl.rp_adv) begin
                n_rp = ptr_next(r_rp);
            end
        end
    end

    assign fill_next = ring_fill(n_wp, n_rp);

    always_comb begin
        unique case (i_ctl.rd_sel)
            RD_OLDEST: rd_addr = r_rp;
            RD_NEWEST: rd_addr = (r_wp == '0) ? LAST_P : r_wp - 1'b1;
            RD_WALK:   rd_addr = r_dptr;
            default:   rd_addr = r_rp;
        endcase
    end

    brf_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.wr_en),
        .i_waddr(r_wp),
        .i_wdata(i_data_in),
        .i_re   (i_ctl.rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= i_ctl.out_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.walk_load) begin
            r_dptr <= start_ptr;
            r_dcnt <= fill_now - off_p;
        end else if (walk_step) begin
            r_dptr <= ptr_next(r_dptr);
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_ctl.out_load) begin
            r_out_ok   <= i_ctl.out_ok;
            r_out_last <= i_ctl.out_last;
            r_out_data <= i_ctl.out_byte ? ram_rdata : '0;
            r_out_fill <= FILL_W'(fill_next);
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.empty     = (r_wp == r_rp);
    assign o_sts.full      = (ptr_next(r_wp) == r_rp);
    assign o_sts.dump_none = (i_offset >= OFFSET_W'(fill_now));
    assign o_sts.walk_done = (r_dcnt == '0);

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out_ok;
    assign o_data_out   = r_out_data;
    assign o_fill_count = r_out_fill;
    assign o_last       = r_out_last;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !o_sts.full)
        else $error("push wrote into a full ring");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rp_adv |-> !o_sts.empty)
        else $error("pop advanced the read pointer of an empty ring");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_ctl.out_load)
        else $error("result register loaded while a stalled beat waits");
    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_step |-> (r_dcnt != '0))
        else $error("dump read past the write pointer");

endmodule

// File: src/brf_ctrl.sv
// Controller of the byte ring FIFO: decodes commands and sequences RAM reads and results.
// Depends on brf_pkg; drives brf_datapath through t_ctl and watches t_sts.
module brf_ctrl import brf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_sts             i_sts,
    output t_ctl             o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   byte_load;
    logic   can_issue;

    always_comb begin
        o_ctl     = '0;
        n_state   = r_state;
        n_pend    = r_pend;
        byte_load = 1'b0;
        can_issue = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.in_ready = i_sts.out_free;
                if (i_valid && i_sts.out_free) begin
                    o_ctl.out_last = 1'b1;
                    unique case (i_command)
                        CMD_PUSH: begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_ok   = !i_sts.full;
                            o_ctl.wr_en    = !i_sts.full;
                        end
                        CMD_POP: begin
                            if (i_sts.empty) begin
                                o_ctl.out_load = 1'b1;
                            end else begin
                                o_ctl.rd_en  = 1'b1;
                                o_ctl.rd_sel = RD_OLDEST;
                                o_ctl.rp_adv = 1'b1;
                                n_state      = S_READ;
                            end
                        end
                        CMD_PEEK: begin
                            if (i_sts.empty) begin
                                o_ctl.out_load = 1'b1;
                            end else begin
                                o_ctl.rd_en  = 1'b1;
                                o_ctl.rd_sel = RD_NEWEST;
                                n_state      = S_READ;
                            end
                        end
                        CMD_DUMP: begin
                            if (i_sts.empty || i_sts.dump_none) begin
                                // Empty ring is refused; a clamped offset gives the terminator.
                                o_ctl.out_load = 1'b1;
                                o_ctl.out_ok   = !i_sts.empty;
                            end else begin
                                o_ctl.walk_load = 1'b1;
                                n_pend          = 1'b0;
                                n_state         = S_DUMP;
                            end
                        end
                        CMD_CLEAR: begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_ok   = 1'b1;
                            o_ctl.clr      = 1'b1;
                        end
                        default: begin
                            o_ctl.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_ok   = 1'b1;
                    o_ctl.out_byte = 1'b1;
                    o_ctl.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DUMP: begin
                // A read is issued only while the walk is not done and the RAM output is not holding
                // an untaken byte or that byte is loaded into the result register in this cycle.
                byte_load = r_pend && i_sts.out_free;
                can_issue = (!r_pend || i_sts.out_free) && !i_sts.walk_done;
                o_ctl.rd_sel = RD_WALK;
                o_ctl.rd_en  = can_issue;
                if (byte_load) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_ok   = 1'b1;
                    o_ctl.out_byte = 1'b1;
                end
                n_pend = can_issue || (r_pend && !byte_load);
                if (!r_pend && i_sts.walk_done && i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_ok   = 1'b1;
                    o_ctl.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && !r_pend && i_sts.walk_done && i_sts.out_free)
        |=> (r_state == S_IDLE))
        else $error("dump did not finish after its terminator");
    a_read_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_ctl.rd_en) |=> (r_state == S_READ))
        else $error("single read issued without entering the read state");

endmodule

// File: src/byte_ring_fifo.sv
// Top level of the byte ring FIFO: joins controller, datapath and the beat interfaces.
// Depends on brf_pkg, brf_if, brf_ram, brf_datapath and brf_ctrl.
//
//   Channel  Dir  Fields                          Beat taken when
//   i_cmd    in   command, data_in, offset        i_cmd.valid && i_cmd.ready
//   o_res    out  ok, data_out, fill_count, last  o_res.valid && o_res.ready
//
// Push, clear, unused codes, refusals and clamped dumps load the result register
// in the cycle the command beat is taken. Pop and peek issue the registered RAM
// read, then load the byte into the result register. Dump sets up the walk
// pointer in the command cycle, issues the first RAM read, then reads and loads
// the bytes in turn, holding while the receiver stalls, and ends with the
// terminator. Reset clears the pointers and the result valid flag;
// the byte store is never cleared and needs no clearing pass. The command side is
// ready only in the idle state with the result register free, so a stalled
// result beat holds off the next command.
module byte_ring_fifo import brf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    brf_cmd_if.sink          i_cmd,
    brf_res_if.source        o_res
);

    t_ctl ctl;
    t_sts sts;

    // The controller owns every decision; the datapath only holds state and data.
    brf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.valid),
        .i_command(i_cmd.command),
        .i_sts    (sts),
        .o_ctl    (ctl)
    );

    brf_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_data_in   (i_cmd.data_in),
        .i_offset    (i_cmd.offset),
        .i_out_ready (o_res.ready),
        .o_sts       (sts),
        .o_out_valid (o_res.valid),
        .o_ok        (o_res.ok),
        .o_data_out  (o_res.data_out),
        .o_fill_count(o_res.fill_count),
        .o_last      (o_res.last)
    );

    // The command side is ready exactly when the controller says so.
    assign i_cmd.ready = ctl.in_ready;

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> (!o_res.valid || o_res.ready))
        else $error("command taken while a stalled result fills the register");
    a_take_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && ctl.out_load) |=> o_res.valid)
        else $error("result of a one-cycle command was not presented");
    a_dump_fill_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last && $past(o_res.valid))
        |-> ($past(o_res.fill_count) == o_res.fill_count || $past(o_res.last)
             || $past(o_res.valid && !o_res.ready)))
        else $error("fill count changed inside a dump");

endmodule
